### rtl/rclfs_pkg.sv
// Package for the radio-control link frame scheduler.
// Holds the shared constants, request codes and sequencer state type.
// No dependencies.
`default_nettype none

package rclfs_pkg;

  // Default channel store depth.
  localparam int MaxChannelsDef = 13;

  // Register reset values and register indexes.
  localparam logic [3:0]  NumChannelsReset = 4'd8;
  localparam logic [15:0] BasePeriodReset  = 16'd3000;
  localparam logic [1:0]  CfgNumChannels   = 2'd0;
  localparam logic [1:0]  CfgBasePeriod    = 2'd1;

  // Channel word conversion.
  localparam int ChanMid = 1500;
  localparam int ChanMin = 1000;
  localparam int ChanMax = 2000;

  // Slot timing in microseconds.
  localparam int AirBaseUs = 432;
  localparam int RxSlotUs  = 50;

  // Counters.
  localparam logic [8:0] FailsafeSends = 9'd500;
  localparam logic [7:0] RateWindow    = 8'd250;
  localparam logic [1:0] MixerLast     = 2'd3;

  // Reception rate scaling: count * 69 / 10, saturated.
  localparam int RateMul    = 69;
  localparam int Div10Mul   = 52429;
  localparam int Div10Shift = 19;
  localparam logic [7:0] RateSat = 8'd255;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_STORE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_START = 2'd2,
    REQ_BIND  = 2'd3
  } req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_EMIT = 4'b0100,
    S_REC  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

### rtl/rclfs_chan_conv.sv
// Converts one signed mixer value into the 11-bit pulse word of a frame.
// Depends on rclfs_pkg for the center and clamp limits.
`default_nettype none

module rclfs_chan_conv
  import rclfs_pkg::*;
(
  input  logic signed [11:0] value,
  output logic [10:0]        pulse
);

  logic signed [12:0] rounded;
  logic signed [12:0] half;
  logic signed [12:0] centered;

  // Halve with truncation toward zero, then center and clamp.
  always_comb begin
    rounded  = 13'(value) + (value[11] ? 13'sd1 : 13'sd0);
    half     = rounded >>> 1;
    centered = half + 13'(ChanMid);
    if (centered < 13'(ChanMin)) begin
      pulse = 11'(ChanMin);
    end else if (centered > 13'(ChanMax)) begin
      pulse = 11'(ChanMax);
    end else begin
      pulse = centered[10:0];
    end
  end

endmodule

`default_nettype wire

### rtl/rc_link_frame_scheduler.sv
// Radio-control link slot scheduler and frame builder.
// Depends on rclfs_pkg and rclfs_chan_conv.
//
// Input words (req_type and fields) are taken when in_valid is high and
// in_stall is low. Store, start and bind words are applied on acceptance
// and produce nothing. A tick word alternates send and receive phases.
// A send tick first runs its period sum and rate scaling, then
// emits one flag byte and two bytes per channel, then one period record
// (2n+2 output words, one per cycle when the receiver does not stall).
// A receive tick runs its period sum, then emits one record.
// All period arithmetic runs through one 16-bit add/subtract unit stepped
// by a small sequencer; that unit sets the calculation length. in_stall
// stays high from a tick's acceptance until its last word is loaded into
// the output register. When the receiver raises out_stall the output
// register holds its word and the sequencer waits. Reset clears all
// counters, flags and the channel store, restores the register defaults
// (8 channels, 3000 us) and leaves the block idle in the send phase.
// cfg_ready is always high; the user must write registers only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module rc_link_frame_scheduler
  import rclfs_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannelsDef
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // Request channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [3:0]         channel_index,
  input  logic signed [11:0] channel_value,
  input  logic [15:0]        elapsed_time,
  input  logic               rx_ready,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [4:0]         byte_index,
  output logic [7:0]         byte_value,
  output logic [15:0]        period_halfus,
  output logic               mixer_trigger,
  output logic               failsafe_ended,
  output logic               rate_valid,
  output logic [7:0]         rate_value,
  output logic               is_last
);

  localparam int CIW = $clog2(MAX_CHANNELS);

  // Configuration registers.
  logic [3:0]  num_channels;
  logic [15:0] base_period_us;

  // Link state.
  logic signed [11:0] channel_store [MAX_CHANNELS];
  logic        rx_phase;
  logic [1:0]  mixer_count;
  logic        failsafe_flag;
  logic [8:0]  failsafe_count;
  logic [7:0]  rate_divider;
  logic [7:0]  rx_count;
  logic [4:0]  frame_size;
  logic [15:0] saved_elapsed;

  // Sequencer and per-tick registers.
  state_t      state;
  logic [1:0]  step;
  logic        is_send;
  logic [15:0] acc;
  logic [4:0]  bidx;
  logic        mix_q;
  logic        fse_q;
  logic        rv_q;
  logic [7:0]  rate_cap;
  logic [14:0] rate_prod;
  logic [7:0]  rate_q;

  logic        in_acc;
  logic        out_free;
  logic [3:0]  n_eff;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign n_eff     = (num_channels > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : num_channels;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels   <= NumChannelsReset;
      base_period_us <= BasePeriodReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CfgNumChannels) begin
        num_channels <= cfg_data[3:0];
      end else if (cfg_index == CfgBasePeriod) begin
        base_period_us <= cfg_data;
      end
    end
  end

  // Channel store writes; out-of-range slots are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        channel_store[i] <= '0;
      end
    end else if (in_acc && req_type == REQ_STORE &&
                 channel_index < 4'(MAX_CHANNELS)) begin
      channel_store[channel_index[CIW-1:0]] <= channel_value;
    end
  end

  // Send-tick counter updates.
  logic [1:0] mixer_inc;
  logic [8:0] fs_inc;
  logic [7:0] div_inc;
  logic       rate_due;
  logic [7:0] rx_base;

  always_comb begin
    mixer_inc = mixer_count + 2'd1;
    fs_inc    = failsafe_count + 9'd1;
    div_inc   = rate_divider + 8'd1;
    rate_due  = (div_inc > RateWindow);
    rx_base   = rate_due ? 8'd0 : rx_count;
  end

  // Shared add/subtract unit: operand chosen by phase and step.
  logic [15:0] operand;
  logic        do_sub;
  logic        calc_done;
  logic [15:0] sum;

  always_comb begin
    operand   = '0;
    do_sub    = 1'b0;
    calc_done = 1'b0;
    if (is_send) begin
      case (step)
        2'd0: operand = {6'd0, frame_size, 5'd0};
        2'd1: begin
          operand   = saved_elapsed;
          calc_done = 1'b1;
        end
        default: operand = '0;
      endcase
    end else begin
      case (step)
        2'd0: operand = 16'(n_eff * RxSlotUs);
        2'd1: begin
          operand = {6'd0, frame_size, 5'd0};
          do_sub  = 1'b1;
        end
        2'd2: begin
          operand = 16'(AirBaseUs);
          do_sub  = 1'b1;
        end
        2'd3: begin
          operand   = saved_elapsed;
          do_sub    = 1'b1;
          calc_done = 1'b1;
        end
        default: operand = '0;
      endcase
    end
    sum = do_sub ? (acc - operand) : (acc + operand);
  end

  // Divide by ten through a reciprocal; exact for the product range.
  logic [31:0] rate_quot;
  assign rate_quot = (32'(rate_prod) * 32'(Div10Mul)) >> Div10Shift;

  // Channel word for the current frame position.
  logic [4:0]     bidx_m1;
  logic [CIW-1:0] ch_sel;
  logic [10:0]    pulse;
  logic [7:0]     frame_byte;

  assign bidx_m1 = bidx - 5'd1;
  assign ch_sel  = CIW'(bidx_m1 >> 1);

  rclfs_chan_conv u_conv (
    .value (channel_store[ch_sel]),
    .pulse (pulse)
  );

  always_comb begin
    if (bidx == 5'd0) begin
      frame_byte = {7'd0, failsafe_flag};
    end else if (bidx[0]) begin
      frame_byte = pulse[7:0];
    end else begin
      frame_byte = {5'd0, pulse[10:8]};
    end
  end

  // Sequencer and link state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step           <= '0;
      is_send        <= 1'b0;
      bidx           <= '0;
      rx_phase       <= 1'b0;
      mixer_count    <= '0;
      failsafe_flag  <= 1'b0;
      failsafe_count <= '0;
      rate_divider   <= '0;
      rx_count       <= '0;
      frame_size     <= '0;
      saved_elapsed  <= '0;
      mix_q          <= 1'b0;
      fse_q          <= 1'b0;
      rv_q           <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (req_type)
              REQ_START: failsafe_flag <= 1'b0;
              REQ_BIND: begin
                failsafe_flag  <= 1'b1;
                failsafe_count <= '0;
              end
              REQ_TICK: begin
                state <= S_CALC;
                step  <= '0;
                bidx  <= '0;
                if (rx_phase) begin
                  // Receive phase: only the period record follows.
                  is_send  <= 1'b0;
                  rx_phase <= 1'b0;
                  mix_q    <= 1'b0;
                  fse_q    <= 1'b0;
                  rv_q     <= 1'b0;
                end else begin
                  is_send       <= 1'b1;
                  rx_phase      <= 1'b1;
                  saved_elapsed <= elapsed_time;
                  frame_size    <= {n_eff, 1'b1};
                  // Mixer prescaler.
                  mix_q       <= (mixer_count == MixerLast);
                  mixer_count <= (mixer_count == MixerLast) ? 2'd0 : mixer_inc;
                  // Failsafe timeout.
                  fse_q <= 1'b0;
                  if (failsafe_flag) begin
                    if (fs_inc >= FailsafeSends) begin
                      failsafe_flag  <= 1'b0;
                      failsafe_count <= '0;
                      fse_q          <= 1'b1;
                    end else begin
                      failsafe_count <= fs_inc;
                    end
                  end else begin
                    failsafe_count <= '0;
                  end
                  // Reception rate window; the report uses the old count.
                  rv_q         <= rate_due;
                  rate_divider <= rate_due ? 8'd0 : div_inc;
                  if (rx_ready && rx_base != RateSat) begin
                    rx_count <= rx_base + 8'd1;
                  end else begin
                    rx_count <= rx_base;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_CALC: begin
          step <= step + 2'd1;
          if (calc_done) begin
            state <= is_send ? S_EMIT : S_REC;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            bidx <= bidx + 5'd1;
            if (bidx == frame_size - 5'd1) begin
              state <= S_REC;
            end
          end
        end
        S_REC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Period accumulator and rate pipeline (payload, no reset needed).
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      acc      <= rx_phase ? base_period_us : 16'(AirBaseUs);
      rate_cap <= (!rx_phase && rate_due) ? rx_count : 8'd0;
    end else if (state == S_CALC) begin
      acc <= sum;
      if (step == 2'd0) begin
        rate_prod <= 15'(rate_cap * RateMul);
      end else if (step == 2'd1) begin
        rate_q <= (rate_quot > 32'(RateSat)) ? RateSat : rate_quot[7:0];
      end
    end
  end

  // Output register.
  logic load_byte;
  logic load_rec;
  assign load_byte = (state == S_EMIT) && out_free;
  assign load_rec  = (state == S_REC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || load_rec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      out_kind       <= 1'b0;
      byte_index     <= bidx;
      byte_value     <= frame_byte;
      period_halfus  <= '0;
      mixer_trigger  <= 1'b0;
      failsafe_ended <= 1'b0;
      rate_valid     <= 1'b0;
      rate_value     <= '0;
      is_last        <= 1'b0;
    end else if (load_rec) begin
      out_kind       <= 1'b1;
      byte_index     <= '0;
      byte_value     <= '0;
      period_halfus  <= {acc[14:0], 1'b0};
      mixer_trigger  <= mix_q;
      failsafe_ended <= fse_q;
      rate_valid     <= rv_q;
      rate_value     <= rate_q;
      is_last        <= 1'b1;
    end
  end

  // Only a period record closes a tick.
  a_last_is_record: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_last == out_kind))
    else $error("is_last disagrees with out_kind");

  // Frame position stays inside the frame while bytes are emitted.
  a_bidx_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (bidx < frame_size))
    else $error("frame byte index beyond frame size");

  // The phase flips only after an accepted tick.
  a_phase_on_tick: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(rx_phase)) |->
      $past(in_valid && !in_stall && req_type == REQ_TICK))
    else $error("phase changed without a tick");

  // A new word is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(byte_index) && $stable(out_kind)))
    else $error("stalled output word overwritten");

endmodule

`default_nettype wire

### bench/tb_rc_link_frame_scheduler.sv
// Self-checking testbench for the radio-control link frame scheduler.
// Depends on rclfs_pkg and the rc_link_frame_scheduler RTL; an internal
// scheduler model predicts every frame byte and slot period record.
`default_nettype none

module tb_rc_link_frame_scheduler;
  import rclfs_pkg::*;

  localparam int ClkHalf       = 6;
  localparam int ResetCycles   = 11;
  localparam int IdlePct       = 28;
  localparam int SettleCycles  = 40;
  localparam int DrainLimit    = 50000;
  localparam int TimeoutCycles = 400000;
  localparam int RxGuardUs     = 100;
  localparam int MaxReports    = 40;

  // One expected result word.
  typedef struct {
    logic        kind;
    logic [4:0]  bidx;
    logic [7:0]  bval;
    logic [15:0] period;
    logic        mix;
    logic        fse;
    logic        rv;
    logic [7:0]  rate;
    logic        last;
  } sched_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CfgNumChannels;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_STORE;
  logic [3:0]  channel_index = '0;
  logic signed [11:0] channel_value = '0;
  logic [15:0] elapsed_time = '0;
  logic        rx_ready = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [4:0]  byte_index;
  logic [7:0]  byte_value;
  logic [15:0] period_halfus;
  logic        mixer_trigger;
  logic        failsafe_ended;
  logic        rate_valid;
  logic [7:0]  rate_value;
  logic        is_last;

  // Idling controls for the sender and the receiver.
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int hold_cycles = 0;
  int err_count = 0;
  int word_seq = 0;

  sched_word_t pending_words[$];

  // Scheduler model state and its copy of the registers.
  int          chan_val[MaxChannelsDef];
  bit          rx_slot;
  int          mix_steps;
  bit          fs_on;
  int          fs_sends;
  int          rate_sends;
  int          rx_pkts;
  int          frame_len;
  logic [15:0] last_elapsed;
  logic [3:0]  cfg_nch;
  logic [15:0] cfg_base;

  rc_link_frame_scheduler dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .elapsed_time(elapsed_time),
    .rx_ready(rx_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .byte_index(byte_index),
    .byte_value(byte_value),
    .period_halfus(period_halfus),
    .mixer_trigger(mixer_trigger),
    .failsafe_ended(failsafe_ended),
    .rate_valid(rate_valid),
    .rate_value(rate_value),
    .is_last(is_last)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Hard limit on the whole run.
  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MaxReports) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
                                word_seq, name, got, want));
    end
  endtask

  function automatic void push_word(logic kind, logic [4:0] bidx, logic [7:0] bval,
                                    logic [15:0] period, logic mix, logic fse,
                                    logic rv, logic [7:0] rate, logic last);
    sched_word_t w;
    w.kind = kind;
    w.bidx = bidx;
    w.bval = bval;
    w.period = period;
    w.mix = mix;
    w.fse = fse;
    w.rv = rv;
    w.rate = rate;
    w.last = last;
    pending_words.push_back(w);
  endfunction

  function automatic void reset_scheduler();
    foreach (chan_val[i]) chan_val[i] = 0;
    rx_slot = 1'b0;
    mix_steps = 0;
    fs_on = 1'b0;
    fs_sends = 0;
    rate_sends = 0;
    rx_pkts = 0;
    frame_len = 0;
    last_elapsed = '0;
    cfg_nch = NumChannelsReset;
    cfg_base = BasePeriodReset;
  endfunction

  // Applies one accepted request word to the model and queues its results.
  function automatic void advance_scheduler(req_t req, logic [3:0] idx,
                                            logic signed [11:0] val,
                                            logic [15:0] el, logic rx);
    int n;
    int air;
    int per;
    int h;
    int r;
    logic [15:0] hv;
    logic mix;
    logic fse;
    logic rv;
    logic [7:0] rate;
    n = (cfg_nch > MaxChannelsDef) ? MaxChannelsDef : int'(cfg_nch);
    mix = 1'b0;
    fse = 1'b0;
    rv = 1'b0;
    rate = '0;
    case (req)
      REQ_STORE: begin
        if (idx < MaxChannelsDef) chan_val[idx] = val;
      end
      REQ_START: fs_on = 1'b0;
      REQ_BIND: begin
        fs_sends = 0;
        fs_on = 1'b1;
      end
      default: begin
        if (rx_slot) begin
          // Receive slot: what remains of the window after the send slot.
          air = 32 * frame_len + AirBaseUs;
          per = RxGuardUs + (n - 2) * RxSlotUs + int'(cfg_base) - air - int'(last_elapsed);
          rx_slot = 1'b0;
          push_word(1'b1, '0, '0, 16'(2 * per), 1'b0, 1'b0, 1'b0, '0, 1'b1);
        end else begin
          mix_steps++;
          if (mix_steps >= 4) begin
            mix_steps = 0;
            mix = 1'b1;
          end
          if (fs_on) begin
            fs_sends++;
            if (fs_sends >= 500) begin
              fs_on = 1'b0;
              fs_sends = 0;
              fse = 1'b1;
            end
          end else begin
            fs_sends = 0;
          end
          // The rate report uses the count from before this send's packet.
          rate_sends++;
          if (rate_sends > 250) begin
            r = rx_pkts * 69 / 10;
            rate = (r > 255) ? 8'd255 : 8'(r);
            rv = 1'b1;
            rx_pkts = 0;
            rate_sends = 0;
          end
          if (rx && rx_pkts < 255) rx_pkts++;
          // Frame: flag byte, then each channel low byte first.
          push_word(1'b0, '0, {7'd0, fs_on}, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
          for (int i = 0; i < n; i++) begin
            h = chan_val[i] / 2 + ChanMid;
            if (h < ChanMin) h = ChanMin;
            if (h > ChanMax) h = ChanMax;
            hv = 16'(h);
            push_word(1'b0, 5'(1 + 2 * i), hv[7:0], '0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            push_word(1'b0, 5'(2 + 2 * i), hv[15:8], '0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
          end
          frame_len = 2 * n + 1;
          last_elapsed = el;
          air = 32 * frame_len + AirBaseUs;
          rx_slot = 1'b1;
          push_word(1'b1, '0, '0, 16'(2 * (air + int'(el))), mix, fse, rv, rate, 1'b1);
        end
      end
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (stall_on) begin
      out_stall <= ($urandom_range(99) < IdlePct);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : check_results
    sched_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", word_seq));
      end else begin
        want = pending_words.pop_front();
        check_field("out_kind", out_kind, want.kind);
        check_field("byte_index", byte_index, want.bidx);
        check_field("byte_value", byte_value, want.bval);
        check_field("period_halfus", period_halfus, want.period);
        check_field("mixer_trigger", mixer_trigger, want.mix);
        check_field("failsafe_ended", failsafe_ended, want.fse);
        check_field("rate_valid", rate_valid, want.rv);
        check_field("rate_value", rate_value, want.rate);
        check_field("is_last", is_last, want.last);
      end
      word_seq++;
    end
  end

  // Offers one request word, with random gaps, and models it on acceptance.
  task automatic send_word(input req_t req, input logic [3:0] idx,
                           input logic [11:0] val, input logic [15:0] el,
                           input logic rx);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    channel_index <= idx;
    channel_value <= val;
    elapsed_time <= el;
    rx_ready <= rx;
    do @(posedge clk); while (in_stall);
    advance_scheduler(req, idx, val, el, rx);
  endtask

  task automatic send_tick(input logic [15:0] el, input logic rx);
    send_word(REQ_TICK, 4'($urandom), 12'($urandom), el, rx);
  endtask

  task automatic send_store(input logic [3:0] idx, input logic [11:0] val);
    send_word(REQ_STORE, idx, val, 16'($urandom), 1'($urandom));
  endtask

  task automatic send_cmd(input req_t req);
    send_word(req, 4'($urandom), 12'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // Stops offering words and waits until every expected word has come or the drain limit runs out.
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgNumChannels) cfg_nch = data[3:0];
    else if (idx == CfgBasePeriod) cfg_base = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] nch, input logic [15:0] base);
    wait_idle();
    cfg_write(CfgNumChannels, {12'($urandom), nch});
    cfg_write(CfgBasePeriod, base);
  endtask

  // Register defaults and zeroed channels, elapsed time at both extremes.
  task automatic test_reset_values();
    send_tick(16'h0000, 1'b0);
    send_tick(16'hFFFF, 1'b1);
  endtask

  // Channel conversion: clamping, truncation toward zero, ignored indexes.
  task automatic test_channel_words();
    send_store(4'd0, -12'sd2048);
    send_store(4'd1, 12'sd2047);
    send_store(4'd2, -12'sd1);
    send_store(4'd3, 12'sd1);
    send_store(4'd4, -12'sd3);
    send_store(4'd5, -12'sd1001);
    send_store(4'd6, -12'sd1003);
    send_store(4'd7, 12'sd999);
    send_store(4'd12, 12'sd1001);
    send_store(4'd13, 12'($urandom));
    send_store(4'd15, 12'($urandom));
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'($urandom), 1'b0);
  endtask

  // Bind raises the failsafe flag in the frame; start clears it.
  task automatic test_failsafe_cmds();
    send_cmd(REQ_BIND);
    send_tick(16'($urandom), 1'b1);
    send_tick(16'($urandom), 1'b0);
    send_cmd(REQ_START);
    send_tick(16'($urandom), 1'b0);
    send_tick(16'($urandom), 1'b1);
  endtask

  // Receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    @(posedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 10; i++) begin
      if (i % 3 == 1) send_store(4'($urandom_range(12)), 12'($urandom));
      else send_tick(16'($urandom), 1'($urandom));
    end
    wait_idle();
  endtask

  task automatic run_random_phase(input logic [3:0] nch, input logic [15:0] base,
                                  input int items);
    int done;
    int pick;
    logic [3:0] idx;
    done = 0;
    set_config(nch, base);
    while (done < items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        idx = 4'($urandom);
        send_store(idx, 12'($urandom));
        if (idx < MaxChannelsDef) done++;
      end else begin
        if (pick < 85) send_tick(16'($urandom), 1'($urandom));
        else if (pick < 93) send_cmd(REQ_START);
        else send_cmd(REQ_BIND);
        done++;
      end
    end
  endtask

  // Random mixes under several settings, one stretch without any idling.
  task automatic test_random_settings();
    run_random_phase(4'd15, 16'hFFFF, 40);
    run_random_phase(4'd0, 16'h0000, 30);
    run_random_phase(4'd1, 16'($urandom), 30);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    run_random_phase(4'd13, 16'd3000, 60);
    gaps_on = 1'b1;
    stall_on = 1'b1;
    run_random_phase(4'($urandom_range(12, 2)), 16'($urandom), 70);
  endtask

  // Tick run after a bind: prescaler wraps and counters carried across sends.
  task automatic test_counter_run();
    set_config(4'd2, 16'($urandom));
    send_cmd(REQ_BIND);
    for (int i = 0; i < 70; i++) begin
      send_tick(16'($urandom), ($urandom_range(99) < 50));
    end
  endtask

  initial begin
    reset_scheduler();
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_channel_words();
    test_failsafe_cmds();
    test_backpressure();
    test_random_settings();
    test_counter_run();

    wait_idle();
    if (pending_words.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));
    end
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
